// ----- hdl/svpwm_pkg.sv -----
// Shared types, constants and the sine table generator of the SVPWM modulator.
// Used by every module of the block; the channel interfaces do not use it.
// Depends on nothing.
package svpwm_pkg;

    // Default configuration of the block.
    localparam int TABLE_ENTRIES = 512;
    localparam int SINE_BITS     = 16;
    localparam int ANGLE_BITS    = 16;

    // Register reset values.
    localparam logic [15:0] BUS_VOLTAGE_RESET = 16'd6144;
    localparam logic [15:0] PWM_PERIOD_RESET  = 16'd5000;

    // Space vector constants in Q16: sqrt3, 3/2 and sqrt3/2.
    localparam int SQRT3_Q16        = 113512;
    localparam int THREE_HALVES_Q16 = 98304;
    localparam int HALF_SQRT3_Q16   = 56756;

    // Datapath widths of the back end. The numerator of an active time after
    // the sine scaling is dropped always fits in NUM_W bits.
    localparam int NUM_W  = 35;
    localparam int DEN_W  = NUM_W + 1;
    localparam int REM_W  = NUM_W + 2;
    localparam int TIME_W = 18;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int SCALE_STEPS = 17;

    // Depth of the job queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Taylor series constants for table generation.
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

    // Configuration register indexes.
    typedef enum logic {
        REG_BUS_VOLTAGE = 1'b0,
        REG_PWM_PERIOD  = 1'b1
    } reg_idx_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_CHECK,
        BK_SCALE,
        BK_EDGE,
        BK_COUNT
    } back_state_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0] bus_voltage;
        logic [15:0] pwm_period;
    } cfg_t;

    // One classified job: sector and the two active-time numerators.
    typedef struct packed {
        logic [2:0]       sector;
        logic [NUM_W-1:0] num1;
        logic [NUM_W-1:0] num2;
    } job_t;

    // First-quadrant sine in Q1.(sine_bits-1) for a Q30 fraction of a quarter turn.
    function automatic longint sine_point(input longint r, input int sine_bits);
        longint x;
        longint x2;
        longint term;
        longint s;
        longint v;
        longint cap;
        x  = (r * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        term = ONE_Q30;
        for (int i = 0; i < 6; i++)
        begin
            term = ONE_Q30 - ((x2 * term) >>> 30) / TAYLOR_DIV[i];
        end
        s = (x * term) >>> 30;
        v = (s + (longint'(1) <<< (30 - sine_bits))) >>> (31 - sine_bits);
        cap = (longint'(1) <<< (sine_bits - 1)) - 1;
        if (v > cap)
        begin
            v = cap;
        end
        return v;
    endfunction

endpackage

// ----- hdl/svpwm_if.sv -----
// Valid/ready channel interfaces of the SVPWM modulator: command in, result out.
// Field widths are fixed by the block's ports; no package dependency.

// Command channel: one d/q voltage pair and an angle per beat.
interface svpwm_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] d_voltage;
    logic signed [15:0] q_voltage;
    logic [15:0]        angle;

    modport source (output valid, d_voltage, q_voltage, angle, input ready);
    modport sink   (input valid, d_voltage, q_voltage, angle, output ready);
endinterface

// Result channel: sector, three compare counts and the limit flag per beat.
interface svpwm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  sector;
    logic [15:0] compare_u;
    logic [15:0] compare_v;
    logic [15:0] compare_w;
    logic        limited;

    modport source (output valid, sector, compare_u, compare_v, compare_w, limited,
                    input ready);
    modport sink   (input valid, sector, compare_u, compare_v, compare_w, limited,
                    output ready);
endinterface

// ----- hdl/svpwm_apb.sv -----
// APB configuration registers of the SVPWM modulator (bus voltage, PWM period).
// Depends on svpwm_pkg for the register indexes, reset values and cfg_t.
module svpwm_apb
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output svpwm_pkg::cfg_t    cfg
);

    logic [15:0]         bus_voltage_reg;
    logic [15:0]         pwm_period_reg;
    logic [15:0]         bus_voltage_next;
    logic [15:0]         pwm_period_next;
    logic                wr_en;
    svpwm_pkg::reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = svpwm_pkg::reg_idx_t'(paddr[2]);

    // Register write decode.
    always_comb
    begin
        bus_voltage_next = bus_voltage_reg;
        pwm_period_next  = pwm_period_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                svpwm_pkg::REG_BUS_VOLTAGE: bus_voltage_next = pwdata[15:0];
                svpwm_pkg::REG_PWM_PERIOD:  pwm_period_next  = pwdata[15:0];
                default:                    bus_voltage_next = bus_voltage_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg <= svpwm_pkg::BUS_VOLTAGE_RESET;
            pwm_period_reg  <= svpwm_pkg::PWM_PERIOD_RESET;
        end
        else
        begin
            bus_voltage_reg <= bus_voltage_next;
            pwm_period_reg  <= pwm_period_next;
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_idx)
            svpwm_pkg::REG_BUS_VOLTAGE: prdata = {16'd0, bus_voltage_reg};
            svpwm_pkg::REG_PWM_PERIOD:  prdata = {16'd0, pwm_period_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.bus_voltage = bus_voltage_reg;
    assign cfg.pwm_period  = pwm_period_reg;

endmodule

// ----- hdl/svpwm_sine_lut.sv -----
// Sine table lookup: one point of a full turn from a quarter-wave constant table.
// Depends on svpwm_pkg for the table generator function.
module svpwm_sine_lut
#(
    parameter int LOG_ENTRIES = $clog2(svpwm_pkg::TABLE_ENTRIES),
    parameter int SINE_BITS   = svpwm_pkg::SINE_BITS
)
(
    input  logic [LOG_ENTRIES:0]         point,
    output logic signed [SINE_BITS-1:0]  value
);

    localparam int QN   = 1 << (LOG_ENTRIES - 2);
    localparam int QI_W = LOG_ENTRIES - 1;

    logic signed [SINE_BITS-1:0] qtab [0:QN];
    logic [1:0]                  quad;
    logic [LOG_ENTRIES-3:0]      offs;
    logic [QI_W-1:0]             idx;
    logic signed [SINE_BITS-1:0] mag;

    // Quarter-wave table, built at elaboration.
    for (genvar m = 0; m <= QN; m++)
    begin : g_tab
        localparam longint R = longint'(m) << (32 - LOG_ENTRIES);
        assign qtab[m] = SINE_BITS'(svpwm_pkg::sine_point(R, SINE_BITS));
    end

    // Mirror in odd quadrants, negate in the lower half turn.
    always_comb
    begin
        quad  = point[LOG_ENTRIES-1:LOG_ENTRIES-2];
        offs  = point[LOG_ENTRIES-3:0];
        idx   = quad[0] ? (QI_W'(QN) - QI_W'(offs)) : QI_W'(offs);
        mag   = qtab[idx];
        value = quad[1] ? -mag : mag;
    end

endmodule

// ----- hdl/svpwm_front.sv -----
// Front end of the SVPWM modulator: sine/cosine interpolation, inverse Park,
// X/Y/Z terms and sector classification in a six-stage pipeline.
// Depends on svpwm_pkg, svpwm_if and svpwm_sine_lut.
module svpwm_front
#(
    parameter int TABLE_ENTRIES = svpwm_pkg::TABLE_ENTRIES,
    parameter int SINE_BITS     = svpwm_pkg::SINE_BITS,
    parameter int ANGLE_BITS    = svpwm_pkg::ANGLE_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    svpwm_cmd_if.sink        cmd,
    output logic             job_valid,
    output svpwm_pkg::job_t  job,
    input  logic             job_ready
);

    localparam int LE    = $clog2(TABLE_ENTRIES);
    localparam int SB    = SINE_BITS;
    localparam int AB    = ANGLE_BITS;
    localparam int IP_W  = SB + AB + 2;
    localparam int PR_W  = SB + 16;
    localparam int AL_W  = SB + 17;
    localparam int XYZ_W = SB + 35;
    localparam int P_W   = SB + 34;
    localparam int NUM_W = svpwm_pkg::NUM_W;

    localparam logic [AB-1:0] QUARTER_TURN = {2'b01, {(AB-2){1'b0}}};
    localparam logic signed [IP_W-1:0]  HALF_F  = IP_W'(1) <<< (AB - 1);
    localparam logic signed [XYZ_W-1:0] K_SQRT3 = XYZ_W'(svpwm_pkg::SQRT3_Q16);
    localparam logic signed [XYZ_W-1:0] K_3H    = XYZ_W'(svpwm_pkg::THREE_HALVES_Q16);
    localparam logic signed [XYZ_W-1:0] K_HS3   = XYZ_W'(svpwm_pkg::HALF_SQRT3_Q16);

    // Linear interpolation between two table points.
    function automatic logic signed [SB-1:0] interp(input logic signed [SB-1:0] a,
                                                    input logic signed [SB-1:0] b,
                                                    input logic [AB-1:0] f);
        logic signed [IP_W-1:0] diff;
        logic signed [IP_W-1:0] prod;
        logic signed [IP_W-1:0] step;
        diff = IP_W'(b) - IP_W'(a);
        prod = diff * signed'(IP_W'(f));
        step = (prod + HALF_F) >>> AB;
        return SB'(step + IP_W'(a));
    endfunction

    logic en;

    // Stage 0: table addressing.
    logic [AB-1:0]    ang_s;
    logic [AB-1:0]    ang_c;
    logic [AB+LE-1:0] pos_s;
    logic [AB+LE-1:0] pos_c;
    logic [LE:0]      ks_a;
    logic [LE:0]      ks_b;
    logic [LE:0]      kc_a;
    logic [LE:0]      kc_b;
    logic signed [SB-1:0] sa_next;
    logic signed [SB-1:0] sb_next;
    logic signed [SB-1:0] ca_next;
    logic signed [SB-1:0] cb_next;

    assign ang_s = AB'(cmd.angle);
    assign ang_c = ang_s + QUARTER_TURN;
    assign pos_s = {ang_s, {LE{1'b0}}};
    assign pos_c = {ang_c, {LE{1'b0}}};
    assign ks_a  = {1'b0, pos_s[AB+LE-1:AB]};
    assign ks_b  = ks_a + (LE+1)'(1);
    assign kc_a  = {1'b0, pos_c[AB+LE-1:AB]};
    assign kc_b  = kc_a + (LE+1)'(1);

    svpwm_sine_lut #(.LOG_ENTRIES(LE), .SINE_BITS(SB)) u_lut_sa (.point(ks_a), .value(sa_next));
    svpwm_sine_lut #(.LOG_ENTRIES(LE), .SINE_BITS(SB)) u_lut_sb (.point(ks_b), .value(sb_next));
    svpwm_sine_lut #(.LOG_ENTRIES(LE), .SINE_BITS(SB)) u_lut_ca (.point(kc_a), .value(ca_next));
    svpwm_sine_lut #(.LOG_ENTRIES(LE), .SINE_BITS(SB)) u_lut_cb (.point(kc_b), .value(cb_next));

    // Pipeline registers.
    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, job_valid_reg;
    logic signed [SB-1:0]    sa_reg, sb_reg, ca_reg, cb_reg;
    logic [AB-1:0]           sf_reg, cf_reg;
    logic signed [15:0]      d1_reg, q1_reg, d2_reg, q2_reg;
    logic signed [SB-1:0]    s_reg, c_reg;
    logic signed [SB-1:0]    s_next, c_next;
    logic signed [PR_W-1:0]  cd_reg, sq_reg, sd_reg, cq_reg;
    logic signed [PR_W-1:0]  cd_next, sq_next, sd_next, cq_next;
    logic signed [AL_W-1:0]  alpha_reg, beta_reg;
    logic signed [AL_W-1:0]  alpha_next, beta_next;
    logic signed [XYZ_W-1:0] x_reg, y_reg, z_reg;
    logic signed [XYZ_W-1:0] x_next, y_next, z_next;
    svpwm_pkg::job_t         job_reg;
    svpwm_pkg::job_t         job_next;

    // The whole pipeline holds while the last stage waits on a full queue.
    assign en        = !(job_valid_reg && !job_ready);
    assign cmd.ready = en;

    // Stage 2: interpolation.
    always_comb
    begin
        s_next = interp(sa_reg, sb_reg, sf_reg);
        c_next = interp(ca_reg, cb_reg, cf_reg);
    end

    // Stage 3: inverse Park products.
    always_comb
    begin
        cd_next = PR_W'(c_reg) * PR_W'(d2_reg);
        sq_next = PR_W'(s_reg) * PR_W'(q2_reg);
        sd_next = PR_W'(s_reg) * PR_W'(d2_reg);
        cq_next = PR_W'(c_reg) * PR_W'(q2_reg);
    end

    // Stage 4: alpha and beta.
    always_comb
    begin
        alpha_next = AL_W'(cd_reg) - AL_W'(sq_reg);
        beta_next  = AL_W'(sd_reg) + AL_W'(cq_reg);
    end

    // Stage 5: X, Y and Z terms.
    always_comb
    begin
        x_next = XYZ_W'(beta_reg) * K_SQRT3;
        y_next = XYZ_W'(alpha_reg) * K_3H + XYZ_W'(beta_reg) * K_HS3;
        z_next = XYZ_W'(beta_reg) * K_HS3 - XYZ_W'(alpha_reg) * K_3H;
    end

    // Stage 6: sector from sign tests and the two active-time numerators.
    always_comb
    begin
        logic [2:0]             n;
        logic signed [XYZ_W-1:0] p1;
        logic signed [XYZ_W-1:0] p2;
        n = {y_reg[XYZ_W-1], z_reg[XYZ_W-1], (!x_reg[XYZ_W-1] && (x_reg != '0))};
        unique case (n)
            3'd1:    begin p1 = z_reg;  p2 = y_reg;  end
            3'd2:    begin p1 = y_reg;  p2 = -x_reg; end
            3'd3:    begin p1 = -z_reg; p2 = x_reg;  end
            3'd4:    begin p1 = -x_reg; p2 = z_reg;  end
            3'd5:    begin p1 = x_reg;  p2 = -y_reg; end
            3'd6:    begin p1 = -y_reg; p2 = -z_reg; end
            default: begin p1 = '0;     p2 = '0;     n = 3'd0; end
        endcase
        if (p1[XYZ_W-1])
        begin
            p1 = '0;
        end
        if (p2[XYZ_W-1])
        begin
            p2 = '0;
        end
        job_next.sector = n;
        job_next.num1   = NUM_W'(p1[P_W-1:SB-1]);
        job_next.num2   = NUM_W'(p2[P_W-1:SB-1]);
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= cmd.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            job_valid_reg <= v5_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
            ca_reg    <= ca_next;
            cb_reg    <= cb_next;
            sf_reg    <= pos_s[AB-1:0];
            cf_reg    <= pos_c[AB-1:0];
            d1_reg    <= cmd.d_voltage;
            q1_reg    <= cmd.q_voltage;
            s_reg     <= s_next;
            c_reg     <= c_next;
            d2_reg    <= d1_reg;
            q2_reg    <= q1_reg;
            cd_reg    <= cd_next;
            sq_reg    <= sq_next;
            sd_reg    <= sd_next;
            cq_reg    <= cq_next;
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            job_reg   <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

// ----- hdl/svpwm_queue.sv -----
// Short job queue between the front and back end of the SVPWM modulator.
// Depends on svpwm_pkg for job_t and the queue depth.
module svpwm_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  svpwm_pkg::job_t  wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output svpwm_pkg::job_t  rd_data
);

    localparam int DEPTH = svpwm_pkg::QUEUE_DEPTH;
    localparam int PW    = svpwm_pkg::QPTR_W;

    svpwm_pkg::job_t   slot_reg [DEPTH];
    logic [PW-1:0]     wptr_reg, rptr_reg;
    logic [PW:0]       fill_reg;
    logic [PW-1:0]     wptr_next, rptr_next;
    logic [PW:0]       fill_next;
    logic              push, pop;

    assign wr_ready = (fill_reg != (PW+1)'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wptr_next = push ? ((wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1)) : wptr_reg;
        rptr_next = pop  ? ((rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1)) : rptr_reg;
        fill_next = fill_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/svpwm_back.sv -----
// Back end of the SVPWM modulator: active times by bit-serial division,
// overmodulation scaling, seven-segment edges and compare counts.
// Depends on svpwm_pkg and svpwm_if.
module svpwm_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  svpwm_pkg::cfg_t  cfg,
    input  logic             job_valid,
    input  svpwm_pkg::job_t  job,
    output logic             job_ready,
    svpwm_res_if.source      res
);

    localparam int NUM_W  = svpwm_pkg::NUM_W;
    localparam int DEN_W  = svpwm_pkg::DEN_W;
    localparam int REM_W  = svpwm_pkg::REM_W;
    localparam int TIME_W = svpwm_pkg::TIME_W;
    localparam int CNT_W  = svpwm_pkg::CNT_W;

    // One restoring division step: returns {remainder, shifted dividend/quotient}.
    function automatic logic [REM_W+NUM_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                        input logic [NUM_W-1:0] sh,
                                                        input logic [DEN_W-1:0] den);
        logic [REM_W-1:0] r;
        logic             ge;
        r  = {rem[REM_W-2:0], sh[NUM_W-1]};
        ge = (r >= REM_W'(den));
        return {(ge ? r - REM_W'(den) : r), sh[NUM_W-2:0], ge};
    endfunction

    // Rounded compare count of an edge time.
    function automatic logic [15:0] to_count(input logic [TIME_W-1:0] t,
                                             input logic [15:0] period);
        logic [33:0] prod;
        prod = 34'(t) * 34'(period) + 34'(1 << 17);
        return prod[33:18];
    endfunction

    svpwm_pkg::back_state_t state_reg, state_next;
    logic [2:0]        sector_reg, sector_next;
    logic              lim_reg, lim_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [REM_W-1:0]  rem1_reg, rem1_next, rem2_reg, rem2_next;
    logic [NUM_W-1:0]  sh1_reg, sh1_next, sh2_reg, sh2_next;
    logic [TIME_W-1:0] tu_reg, tu_next, tv_reg, tv_next, tw_reg, tw_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_sector_reg, out_sector_next;
    logic [15:0]       out_u_reg, out_u_next, out_v_reg, out_v_next, out_w_reg, out_w_next;
    logic              out_lim_reg, out_lim_next;

    // Sequencer: next state and datapath.
    always_comb
    begin
        logic [REM_W+NUM_W-1:0] step1;
        logic [REM_W+NUM_W-1:0] step2;
        logic [DEN_W-1:0]       sum;
        logic [TIME_W-1:0]      t1, t2, ta, tb, tc;

        state_next      = state_reg;
        sector_next     = sector_reg;
        lim_next        = lim_reg;
        cnt_next        = cnt_reg;
        den_next        = den_reg;
        rem1_next       = rem1_reg;
        rem2_next       = rem2_reg;
        sh1_next        = sh1_reg;
        sh2_next        = sh2_reg;
        tu_next         = tu_reg;
        tv_next         = tv_reg;
        tw_next         = tw_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_sector_next = out_sector_reg;
        out_u_next      = out_u_reg;
        out_v_next      = out_v_reg;
        out_w_next      = out_w_reg;
        out_lim_next    = out_lim_reg;
        job_ready       = 1'b0;

        step1 = div_step(rem1_reg, sh1_reg, den_reg);
        step2 = div_step(rem2_reg, sh2_reg, den_reg);
        sum   = DEN_W'(sh1_reg) + DEN_W'(sh2_reg);
        t1    = TIME_W'(sh1_reg[16:0]);
        t2    = TIME_W'(sh2_reg[16:0]);
        ta    = TIME_W'(65536) - t1 - t2;
        tb    = ta + {t1[TIME_W-2:0], 1'b0};
        tc    = tb + {t2[TIME_W-2:0], 1'b0};

        unique case (state_reg)
            svpwm_pkg::BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    sector_next = job.sector;
                    lim_next    = 1'b0;
                    den_next    = (cfg.bus_voltage == '0) ? DEN_W'(1)
                                                          : DEN_W'(cfg.bus_voltage);
                    rem1_next   = '0;
                    rem2_next   = '0;
                    sh1_next    = job.num1;
                    sh2_next    = job.num2;
                    cnt_next    = CNT_W'(NUM_W - 1);
                    state_next  = svpwm_pkg::BK_DIV;
                end
            end
            svpwm_pkg::BK_DIV, svpwm_pkg::BK_SCALE:
            begin
                {rem1_next, sh1_next} = step1;
                {rem2_next, sh2_next} = step2;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = (state_reg == svpwm_pkg::BK_DIV) ? svpwm_pkg::BK_CHECK
                                                                  : svpwm_pkg::BK_EDGE;
                end
            end
            svpwm_pkg::BK_CHECK:
            begin
                // Overmodulation: rescale both times to T*65536/(T1+T2).
                if (sum > DEN_W'(65536))
                begin
                    lim_next   = 1'b1;
                    den_next   = sum;
                    rem1_next  = REM_W'(sh1_reg[NUM_W-1:1]);
                    rem2_next  = REM_W'(sh2_reg[NUM_W-1:1]);
                    sh1_next   = {sh1_reg[0], {(NUM_W-1){1'b0}}};
                    sh2_next   = {sh2_reg[0], {(NUM_W-1){1'b0}}};
                    cnt_next   = CNT_W'(svpwm_pkg::SCALE_STEPS - 1);
                    state_next = svpwm_pkg::BK_SCALE;
                end
                else
                begin
                    state_next = svpwm_pkg::BK_EDGE;
                end
            end
            svpwm_pkg::BK_EDGE:
            begin
                // Seven-segment edge times routed to phases by sector.
                unique case (sector_reg)
                    3'd1:    begin tu_next = tb; tv_next = ta; tw_next = tc; end
                    3'd2:    begin tu_next = ta; tv_next = tc; tw_next = tb; end
                    3'd3:    begin tu_next = ta; tv_next = tb; tw_next = tc; end
                    3'd4:    begin tu_next = tc; tv_next = tb; tw_next = ta; end
                    3'd5:    begin tu_next = tc; tv_next = ta; tw_next = tb; end
                    3'd6:    begin tu_next = tb; tv_next = tc; tw_next = ta; end
                    default: begin tu_next = ta; tv_next = ta; tw_next = ta; end
                endcase
                state_next = svpwm_pkg::BK_COUNT;
            end
            svpwm_pkg::BK_COUNT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sector_next = sector_reg;
                    out_u_next      = to_count(tu_reg, cfg.pwm_period);
                    out_v_next      = to_count(tv_reg, cfg.pwm_period);
                    out_w_next      = to_count(tw_reg, cfg.pwm_period);
                    out_lim_next    = lim_reg;
                    state_next      = svpwm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = svpwm_pkg::BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svpwm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output registers.
    always_ff @(posedge clk)
    begin
        sector_reg     <= sector_next;
        lim_reg        <= lim_next;
        cnt_reg        <= cnt_next;
        den_reg        <= den_next;
        rem1_reg       <= rem1_next;
        rem2_reg       <= rem2_next;
        sh1_reg        <= sh1_next;
        sh2_reg        <= sh2_next;
        tu_reg         <= tu_next;
        tv_reg         <= tv_next;
        tw_reg         <= tw_next;
        out_sector_reg <= out_sector_next;
        out_u_reg      <= out_u_next;
        out_v_reg      <= out_v_next;
        out_w_reg      <= out_w_next;
        out_lim_reg    <= out_lim_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.sector    = out_sector_reg;
    assign res.compare_u = out_u_reg;
    assign res.compare_v = out_v_reg;
    assign res.compare_w = out_w_reg;
    assign res.limited   = out_lim_reg;

endmodule

// ----- hdl/svpwm_modulator.sv -----
// Seven-segment space vector PWM modulator: d/q command and angle in, sector,
// three compare counts and limit flag out. A command beat passes through 6 front stages,
// the job queue and the bit-serial active-time divider of the back end, which takes longer
// when the active times are rescaled. The back end takes a new job only once it is done
// with the last one; beats are taken back to back until the front pipeline and 4-deep queue fill.
// Reset (rst_n, asynchronous) empties the pipeline and queue; bus voltage 6144, period 5000.
module svpwm_modulator
#(
    parameter int TABLE_ENTRIES = svpwm_pkg::TABLE_ENTRIES,
    parameter int SINE_BITS     = svpwm_pkg::SINE_BITS,
    parameter int ANGLE_BITS    = svpwm_pkg::ANGLE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    svpwm_cmd_if.sink   cmd,
    svpwm_res_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    svpwm_pkg::cfg_t cfg;
    svpwm_pkg::job_t front_job;
    svpwm_pkg::job_t back_job;
    logic            front_valid;
    logic            front_ready;
    logic            back_valid;
    logic            back_ready;

    // Configuration registers.
    svpwm_apb u_apb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Trig, inverse Park and sector classification.
    svpwm_front
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SINE_BITS     (SINE_BITS),
        .ANGLE_BITS    (ANGLE_BITS)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .job_valid (front_valid),
        .job       (front_job),
        .job_ready (front_ready)
    );

    // Job queue.
    svpwm_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_job)
    );

    // Active times and compare counts.
    svpwm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (back_valid),
        .job       (back_job),
        .job_ready (back_ready),
        .res       (res)
    );

endmodule
